// ===== rtl/core/lzw_pkg.sv =====
// Shared types and constants for the LZW compressor core.
// No dependencies; lzw_hash and lzw_compressor_core import this package.
package lzw_pkg;

    // Code space and dictionary geometry (TABLE_DEPTH must be a power of two)
    localparam int CODE_BITS      = 12;
    localparam int TABLE_DEPTH    = 8192;
    localparam int IDX_BITS       = $clog2(TABLE_DEPTH);
    localparam int PROBE_BITS     = IDX_BITS + 1;
    localparam int BYTE_BITS      = 8;
    localparam int KEY_BITS       = CODE_BITS + BYTE_BITS;
    localparam int NFC_BITS       = CODE_BITS + 1;
    localparam int EPOCH_BITS     = 8;

    // Hash multiplier and its width
    localparam int HASH_MULT      = 40503;
    localparam int HASH_MULT_BITS = 16;
    localparam int PROD_BITS      = KEY_BITS + HASH_MULT_BITS;

    // First dynamic code and the end of the code space
    localparam int FIRST_FREE     = 256;
    localparam int CODE_LIMIT     = 1 << CODE_BITS;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 end_of_stream;
    } code_item_t;

    // One dictionary slot; a slot is live when its epoch matches the current one
    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [KEY_BITS-1:0]   key;
        logic [CODE_BITS-1:0]  code;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Request to the hash unit
    typedef struct packed {
        logic                load;
        logic [KEY_BITS-1:0] key;
    } hash_req_t;

endpackage

// ===== rtl/core/lzw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency; width and depth come from its parameters.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lzw_hash.sv =====
// Registered multiplicative hash of a (prefix, byte) key to a table slot.
// Depends on lzw_pkg.
module lzw_hash
    import lzw_pkg::*;
(
    input  logic                clk,
    input  hash_req_t           req,
    output logic [IDX_BITS-1:0] pos
);

    logic [PROD_BITS-1:0] prod;
    logic [IDX_BITS-1:0]  pos_reg;
    logic [IDX_BITS-1:0]  pos_next;

    // Multiply by the hash constant and keep the low index bits (mod table depth)
    always_comb
    begin
        prod     = PROD_BITS'(req.key) * PROD_BITS'(HASH_MULT);
        pos_next = req.load ? prod[IDX_BITS-1:0] : pos_reg;
    end

    // Hold the start slot for the probe sequence
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

// ===== rtl/core/lzw_compressor_core.sv =====
// LZW compressor core with 12-bit codes and a linear-probed hash dictionary.
// Depends on lzw_pkg, lzw_hash and lzw_ram.
//
// A byte that starts a stream only becomes the prefix; any other byte is hashed, then
// the dictionary is read slot by slot until a hit, a free slot or a full sweep, and a
// miss emits a code, held while the output stalls. The single read port of the
// dictionary RAM gives one slot read per cycle. Dictionary slots carry an
// 8-bit epoch; ending a stream just advances the epoch. After reset, and after every
// 255th stream when the epoch wraps, a clearing pass over all 8192 slots (one slot per
// cycle) runs, during which no byte is taken. Up to two codes result from one byte;
// the second one is marked end_of_stream.
module lzw_compressor_core
    import lzw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_reg, clr_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [CODE_BITS-1:0]  prefix_reg, prefix_next;
    logic                  have_prefix_reg, have_prefix_next;
    logic [NFC_BITS-1:0]   nfc_reg, nfc_next;
    logic [BYTE_BITS-1:0]  byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [IDX_BITS-1:0]   pos_reg, pos_next;
    logic [PROBE_BITS-1:0] probe_cnt_reg, probe_cnt_next;
    logic [CODE_BITS-1:0]  emit_code_reg, emit_code_next;
    logic                  out_valid_reg, out_valid_next;
    code_item_t            out_data_reg, out_data_next;

    logic                  accept;
    logic                  out_free;
    hash_req_t             hash_req;
    logic [IDX_BITS-1:0]   hash_pos;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    entry_t                wr_entry;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    entry_t                rd_entry;
    logic [PROBE_BITS-1:0] probe_cnt_inc;
    logic [EPOCH_BITS-1:0] epoch_inc;

    assign byte_stall = (state_reg != S_IDLE);
    assign accept     = byte_valid && !byte_stall;
    assign out_free   = !out_valid_reg || !code_stall;

    // Hash the new key as the byte is taken
    assign hash_req.load = accept && have_prefix_reg;
    assign hash_req.key  = {prefix_reg, byte_data.data_byte};

    lzw_hash u_hash (
        .clk (clk),
        .req (hash_req),
        .pos (hash_pos)
    );

    lzw_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign probe_cnt_inc = probe_cnt_reg + PROBE_BITS'(1);
    assign epoch_inc     = epoch_reg + EPOCH_BITS'(1);

    // Sequencer: one dictionary access per cycle, so reads never overlap a write
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        epoch_next       = epoch_reg;
        prefix_next      = prefix_reg;
        have_prefix_next = have_prefix_reg;
        nfc_next         = nfc_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        key_next         = key_reg;
        pos_next         = pos_reg;
        probe_cnt_next   = probe_cnt_reg;
        emit_code_next   = emit_code_reg;
        out_valid_next   = out_valid_reg && code_stall;
        out_data_next    = out_data_reg;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_entry         = '{epoch: epoch_reg, key: key_reg, code: nfc_reg[CODE_BITS-1:0]};
        rd_en            = 1'b0;
        rd_addr          = pos_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep every slot to epoch zero
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_entry = '0;
                clr_next = clr_reg + IDX_BITS'(1);
                if (clr_reg == {IDX_BITS{1'b1}})
                begin
                    epoch_next = EPOCH_BITS'(1);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = byte_data.data_byte;
                    last_next = byte_data.last_byte;
                    key_next  = {prefix_reg, byte_data.data_byte};
                    if (!have_prefix_reg)
                    begin
                        // First byte of a stream becomes the prefix
                        prefix_next      = CODE_BITS'(byte_data.data_byte);
                        have_prefix_next = 1'b1;
                        state_next       = byte_data.last_byte ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // Read the home slot
                rd_en          = 1'b1;
                rd_addr        = hash_pos;
                pos_next       = hash_pos;
                probe_cnt_next = '0;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_entry.epoch == epoch_reg && rd_entry.key == key_reg)
                begin
                    // Hit: advance the prefix
                    prefix_next = rd_entry.code;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
                else if (rd_entry.epoch != epoch_reg ||
                         probe_cnt_inc == PROBE_BITS'(TABLE_DEPTH))
                begin
                    // Miss: queue the prefix code, insert if a slot and a code are free
                    if (rd_entry.epoch != epoch_reg && nfc_reg < NFC_BITS'(CODE_LIMIT))
                    begin
                        wr_en    = 1'b1;
                        nfc_next = nfc_reg + NFC_BITS'(1);
                    end
                    emit_code_next = prefix_reg;
                    prefix_next    = CODE_BITS'(byte_reg);
                    state_next     = S_EMIT;
                end
                else
                begin
                    // Occupied by another key: probe the next slot
                    pos_next       = pos_reg + IDX_BITS'(1);
                    probe_cnt_next = probe_cnt_inc;
                    rd_en          = 1'b1;
                    rd_addr        = pos_reg + IDX_BITS'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{code: emit_code_reg, end_of_stream: 1'b0};
                    state_next     = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    // Flush the last prefix and drop the dictionary
                    out_valid_next   = 1'b1;
                    out_data_next    = '{code: prefix_reg, end_of_stream: 1'b1};
                    prefix_next      = '0;
                    have_prefix_next = 1'b0;
                    nfc_next         = NFC_BITS'(FIRST_FREE);
                    epoch_next       = epoch_inc;
                    if (epoch_inc == '0)
                    begin
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            epoch_reg       <= '0;
            prefix_reg      <= '0;
            have_prefix_reg <= 1'b0;
            nfc_reg         <= NFC_BITS'(FIRST_FREE);
            probe_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            epoch_reg       <= epoch_next;
            prefix_reg      <= prefix_next;
            have_prefix_reg <= have_prefix_next;
            nfc_reg         <= nfc_next;
            probe_cnt_reg   <= probe_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        emit_code_reg <= emit_code_next;
        out_data_reg  <= out_data_next;
    end

    assign code_valid = out_valid_reg;
    assign code_data  = out_data_reg;

    // Code counter never passes the end of the code space
    assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg <= NFC_BITS'(CODE_LIMIT))
        else $error("next free code beyond code space");

    // The live epoch is never the cleared one outside the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |-> (epoch_reg != '0))
        else $error("live epoch zero outside clearing pass");

    // Dictionary writes happen only while clearing or resolving a probe
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_CHECK))
        else $error("dictionary write outside clear or probe");

    // Flushing the final code ends the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && out_free) |=> (!have_prefix_reg && code_valid &&
                                                code_data.end_of_stream))
        else $error("stream not closed after final code");

endmodule
